// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/bcpe_pkg.sv =====
// Shared types, codes and sizes of the Bezier curve point evaluator.
// No dependencies; used by bcpe_lerp3 and the top level.
package bcpe_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int T_W        = 17;
  localparam int PROD_W     = 51;
  localparam logic [T_W-1:0] T_ONE = 17'h10000;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_EVAL   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW,
    S_DRAIN,
    S_FIN_RD,
    S_FIN_WAIT,
    S_RESP
  } state_t;

  // lane 0 = x, lane 1 = y, lane 2 = z
  typedef logic [2:0][31:0] pt_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] addr;
    pt_t              a;
    pt_t              b;
  } lerp_req_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] addr;
    pt_t              val;
  } lerp_rsp_t;

endpackage

// ===== hw/rtl/bcpe_lerp3.sv =====
// Two-stage fixed-point lerp a + ((b - a) * t >>> 16) on three lanes.
// Depends on bcpe_pkg. Stage one registers the products, stage two adds.
module bcpe_lerp3 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bcpe_pkg::lerp_req_t         req,
  input  logic [bcpe_pkg::T_W-1:0]    t,
  output bcpe_pkg::lerp_rsp_t         rsp
);

  logic                                       v_r;
  logic [bcpe_pkg::IDX_W-1:0]                 addr_r;
  bcpe_pkg::pt_t                              a_r;
  logic signed [2:0][bcpe_pkg::PROD_W-1:0]    prod_r;
  logic signed [2:0][bcpe_pkg::PROD_W-1:0]    prod_nxt;
  bcpe_pkg::pt_t                              sum;

  always_comb begin
    logic signed [32:0] diff;
    for (int l = 0; l < 3; l++) begin
      diff = $signed({req.b[l][31], req.b[l]}) - $signed({req.a[l][31], req.a[l]});
      prod_nxt[l] = bcpe_pkg::PROD_W'(diff * $signed({1'b0, t}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= req.addr;
    a_r    <= req.a;
    prod_r <= prod_nxt;
  end

  always_comb begin
    logic signed [34:0] q;
    logic signed [34:0] s;
    for (int l = 0; l < 3; l++) begin
      q = prod_r[l][bcpe_pkg::PROD_W-1:16];
      s = $signed({{3{a_r[l][31]}}, a_r[l]}) + q;
      sum[l] = s[31:0];
    end
  end

  assign rsp.valid = v_r;
  assign rsp.addr  = addr_r;
  assign rsp.val   = sum;

endmodule

// ===== hw/rtl/bezier_curve_point_evaluator_core.sv =====
// Bezier curve point evaluator: keeps up to 16 control points (signed Q16.16) in a point
// memory and evaluates the curve at t (unsigned Q1.16) by de Casteljau reduction through a
// work memory, one result item per command. An evaluate reads each row through the one
// read port of the work memory, one lerp per cycle along a row, and drains the lerp
// pipeline between rows. Depends on bcpe_pkg, bcpe_lerp3 and assert_macros.svh.
`include "assert_macros.svh"

module bezier_curve_point_evaluator_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,   // t[16:0], px[48:17], py[80:49], pz[112:81], zero pad
  input  logic [1:0]   in_tuser,   // op[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // cx[31:0], cy[63:32], cz[95:64]
  output logic [1:0]   out_tuser   // status[1:0]
);

  localparam int IW = bcpe_pkg::IDX_W;
  localparam int CW = bcpe_pkg::CNT_W;

  bcpe_pkg::state_t            state_r, state_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [CW-1:0]               len_r, len_nxt;
  logic [CW-1:0]               ridx_r, ridx_nxt;
  logic [bcpe_pkg::T_W-1:0]    t_r, t_nxt;
  logic                        use_pts_r, use_pts_nxt;
  bcpe_pkg::pt_t               res_r, res_nxt;
  logic [1:0]                  stat_r, stat_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [95:0]                 out_data_r, out_data_nxt;
  logic [1:0]                  out_stat_r, out_stat_nxt;

  logic                        rd_vld_r;
  logic [IW-1:0]               rd_idx_r;
  logic                        rd_src_r;
  bcpe_pkg::pt_t               prev_r;

  bcpe_pkg::pt_t               pts_mem [bcpe_pkg::MAX_POINTS];
  bcpe_pkg::pt_t               wrk_mem [bcpe_pkg::MAX_POINTS];
  bcpe_pkg::pt_t               pts_q, wrk_q, rdata;
  logic [IW-1:0]               raddr;

  logic                        accept;
  logic                        pts_we;
  logic [bcpe_pkg::T_W-1:0]    in_t;
  logic [bcpe_pkg::T_W-1:0]    t_sat;
  logic                        busy;

  bcpe_pkg::lerp_req_t         lerp_req;
  bcpe_pkg::lerp_rsp_t         lerp_rsp;

  assign in_tready = (state_r == bcpe_pkg::S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_t      = in_tdata[16:0];
  assign t_sat     = (in_t > bcpe_pkg::T_ONE) ? bcpe_pkg::T_ONE : in_t;
  assign pts_we    = accept && (in_tuser == bcpe_pkg::OP_APPEND) &&
                     (cnt_r < CW'(bcpe_pkg::MAX_POINTS));
  assign raddr     = (state_r == bcpe_pkg::S_ROW) ? ridx_r[IW-1:0] : '0;
  assign rdata     = rd_src_r ? pts_q : wrk_q;
  assign busy      = rd_vld_r || lerp_rsp.valid;

  always_ff @(posedge clk) begin
    if (pts_we) begin
      pts_mem[cnt_r[IW-1:0]] <= in_tdata[112:17];
    end
    pts_q <= pts_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (lerp_rsp.valid) begin
      wrk_mem[lerp_rsp.addr] <= lerp_rsp.val;
    end
    wrk_q <= wrk_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == bcpe_pkg::S_ROW);
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= raddr;
    rd_src_r <= use_pts_r;
    if (rd_vld_r) begin
      prev_r <= rdata;
    end
  end

  assign lerp_req.valid = rd_vld_r && (rd_idx_r != '0);
  assign lerp_req.addr  = rd_idx_r - IW'(1);
  assign lerp_req.a     = prev_r;
  assign lerp_req.b     = rdata;

  bcpe_lerp3 u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (lerp_req),
    .t     (t_r),
    .rsp   (lerp_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    ridx_nxt      = ridx_r;
    t_nxt         = t_r;
    use_pts_nxt   = use_pts_r;
    res_nxt       = res_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      bcpe_pkg::S_IDLE: begin
        if (accept) begin
          res_nxt   = '0;
          stat_nxt  = bcpe_pkg::STAT_OK;
          state_nxt = bcpe_pkg::S_RESP;
          case (in_tuser)
            bcpe_pkg::OP_CLEAR: begin
              cnt_nxt = '0;
            end
            bcpe_pkg::OP_APPEND: begin
              if (pts_we) begin
                cnt_nxt = cnt_r + CW'(1);
              end else begin
                stat_nxt = bcpe_pkg::STAT_FULL;
              end
            end
            bcpe_pkg::OP_EVAL: begin
              t_nxt       = t_sat;
              len_nxt     = cnt_r;
              ridx_nxt    = '0;
              use_pts_nxt = 1'b1;
              if (cnt_r == '0) begin
                stat_nxt = bcpe_pkg::STAT_EMPTY;
              end else if (cnt_r == CW'(1)) begin
                state_nxt = bcpe_pkg::S_FIN_RD;
              end else begin
                state_nxt = bcpe_pkg::S_ROW;
              end
            end
            default: begin
            end
          endcase
        end
      end
      bcpe_pkg::S_ROW: begin
        ridx_nxt = ridx_r + CW'(1);
        if (ridx_r == len_r - CW'(1)) begin
          state_nxt = bcpe_pkg::S_DRAIN;
        end
      end
      bcpe_pkg::S_DRAIN: begin
        if (!busy) begin
          use_pts_nxt = 1'b0;
          len_nxt     = len_r - CW'(1);
          ridx_nxt    = '0;
          if (len_r == CW'(2)) begin
            state_nxt = bcpe_pkg::S_FIN_RD;
          end else begin
            state_nxt = bcpe_pkg::S_ROW;
          end
        end
      end
      bcpe_pkg::S_FIN_RD: begin
        state_nxt = bcpe_pkg::S_FIN_WAIT;
      end
      bcpe_pkg::S_FIN_WAIT: begin
        res_nxt   = rdata;
        stat_nxt  = bcpe_pkg::STAT_OK;
        state_nxt = bcpe_pkg::S_RESP;
      end
      bcpe_pkg::S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          out_stat_nxt  = stat_r;
          state_nxt     = bcpe_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bcpe_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bcpe_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    ridx_r     <= ridx_nxt;
    t_r        <= t_nxt;
    use_pts_r  <= use_pts_nxt;
    res_r      <= res_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

  `ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CW'(bcpe_pkg::MAX_POINTS))
  `ASSERT_IMPL(a_wr_in_eval, lerp_rsp.valid,
               state_r == bcpe_pkg::S_ROW || state_r == bcpe_pkg::S_DRAIN)
  `ASSERT_IMPL(a_fin_drained, state_r == bcpe_pkg::S_FIN_RD, !rd_vld_r && !lerp_rsp.valid)
  `ASSERT_NEXT(a_full_hold,
               accept && in_tuser == bcpe_pkg::OP_APPEND &&
               cnt_r == CW'(bcpe_pkg::MAX_POINTS),
               cnt_r == CW'(bcpe_pkg::MAX_POINTS))

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for bezier_curve_point_evaluator_core: drives clear, append,
// evaluate and unused-op items and checks every result item against a de Casteljau
// predictor. Depends on bcpe_pkg and the core RTL.
module testbench;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_ITEMS = 1200;

  typedef struct {
    bcpe_pkg::pt_t     coord;
    bcpe_pkg::status_t status;
  } curve_result_t;

  class bezier_point_scoreboard;
    int            pt_x[bcpe_pkg::MAX_POINTS];
    int            pt_y[bcpe_pkg::MAX_POINTS];
    int            pt_z[bcpe_pkg::MAX_POINTS];
    int unsigned   n_pts;
    curve_result_t pending[$];
    int            errors;

    function new();
      n_pts  = 0;
      errors = 0;
    endfunction

    function int lerp(int a, int b, int unsigned t);
      longint prod;
      prod = (longint'(b) - longint'(a)) * longint'(t);
      return int'(longint'(a) + (prod >>> 16));
    endfunction

    function int casteljau(int src[bcpe_pkg::MAX_POINTS], int unsigned n, int unsigned t);
      int w[bcpe_pkg::MAX_POINTS];
      w = src;
      for (int r = n; r > 1; r--)
        for (int i = 0; i + 1 < r; i++)
          w[i] = lerp(w[i], w[i+1], t);
      return w[0];
    endfunction

    function void note_command(logic [1:0] op, logic [bcpe_pkg::T_W-1:0] t_raw,
                               int px, int py, int pz);
      curve_result_t res;
      int unsigned   t;
      res.coord  = '0;
      res.status = bcpe_pkg::STAT_OK;
      t = (t_raw > bcpe_pkg::T_ONE) ? 32'(bcpe_pkg::T_ONE) : 32'(t_raw);
      case (op)
        bcpe_pkg::OP_CLEAR: n_pts = 0;
        bcpe_pkg::OP_APPEND: begin
          if (n_pts < bcpe_pkg::MAX_POINTS) begin
            pt_x[n_pts] = px;
            pt_y[n_pts] = py;
            pt_z[n_pts] = pz;
            n_pts++;
          end else begin
            res.status = bcpe_pkg::STAT_FULL;
          end
        end
        bcpe_pkg::OP_EVAL: begin
          if (n_pts == 0) begin
            res.status = bcpe_pkg::STAT_EMPTY;
          end else begin
            res.coord[0] = casteljau(pt_x, n_pts, t);
            res.coord[1] = casteljau(pt_y, n_pts, t);
            res.coord[2] = casteljau(pt_z, n_pts, t);
          end
        end
        default: ;
      endcase
      pending.push_back(res);
    endfunction

    function void check_result(logic [95:0] data, logic [1:0] status);
      curve_result_t want;
      bcpe_pkg::pt_t got;
      if (pending.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h status %0d",
                 $time, data, status);
        errors++;
        return;
      end
      want = pending.pop_front();
      got  = data;
      for (int k = 0; k < 3; k++) begin
        if (got[k] !== want.coord[k]) begin
          $display("%0t: coord %0d mismatch, expected %h actual %h",
                   $time, k, want.coord[k], got[k]);
          errors++;
        end
      end
      if (status !== want.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d", $time, want.status, status);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending.size();
    endfunction
  endclass

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [119:0] in_tdata   = '0;
  logic [1:0]   in_tuser   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;
  logic [1:0]   out_tuser;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int quiet_cycles   = 0;

  bezier_point_scoreboard point_board = new();

  bezier_curve_point_evaluator_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        point_board.check_result(out_tdata, out_tuser);
      end
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
    end
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("%0t: no item accepted for %0d cycles", $time, STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int rand_coord();
    case ($urandom_range(7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return int'($urandom_range(0, 262143)) - 131072;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [bcpe_pkg::T_W-1:0] rand_param();
    case ($urandom_range(15))
      0:       return '0;
      1:       return bcpe_pkg::T_ONE;
      2:       return bcpe_pkg::T_W'($urandom_range(65537, 131071));
      default: return bcpe_pkg::T_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_command(logic [1:0] op, logic [bcpe_pkg::T_W-1:0] t,
                              int px, int py, int pz);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, pz, py, px, t};
    do @(posedge clk); while (!in_tready);
    point_board.note_command(op, t, px, py, pz);
  endtask

  task automatic send_random(logic [1:0] op);
    send_command(op, rand_param(), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic run_random(int count);
    int         done;
    int         n_append;
    int         n_eval;
    logic [1:0] op;
    done = 0;
    while (done < count) begin
      if ($urandom_range(99) < 8) begin
        op = 2'($urandom_range(3));
        send_command(op, bcpe_pkg::T_W'($urandom_range(0, 131071)),
                     $urandom, $urandom, $urandom);
        if (op != OP_UNUSED) done++;
      end else begin
        send_random(bcpe_pkg::OP_CLEAR);
        case ($urandom_range(19))
          0:          n_append = 0;
          1, 2:       n_append = $urandom_range(13, bcpe_pkg::MAX_POINTS + 2);
          3, 4, 5, 6: n_append = $urandom_range(6, 12);
          default:    n_append = $urandom_range(1, 5);
        endcase
        for (int i = 0; i < n_append; i++) begin
          send_random(bcpe_pkg::OP_APPEND);
          if ($urandom_range(3) == 0) begin
            send_random(bcpe_pkg::OP_EVAL);
            done++;
          end
        end
        n_eval = $urandom_range(1, 4);
        for (int i = 0; i < n_eval; i++) send_random(bcpe_pkg::OP_EVAL);
        done += 1 + n_append + n_eval;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_command(bcpe_pkg::OP_EVAL, 17'h0_8000, 0, 0, 0);
    send_command(OP_UNUSED, 17'h1_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_command(bcpe_pkg::OP_APPEND, 17'h0_0000, 32'h7fff_ffff, 32'h8000_0000,
                 32'h0001_0000);
    send_command(bcpe_pkg::OP_EVAL, 17'd12345, 0, 0, 0);
    send_command(bcpe_pkg::OP_APPEND, 17'h1_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 32'hffff_0000);
    send_command(bcpe_pkg::OP_EVAL, 17'h0_0000, 0, 0, 0);
    send_command(bcpe_pkg::OP_EVAL, bcpe_pkg::T_ONE, 0, 0, 0);
    send_command(bcpe_pkg::OP_EVAL, 17'h1_ffff, 0, 0, 0);
    send_command(bcpe_pkg::OP_EVAL, 17'h0_8000, 0, 0, 0);
    send_command(bcpe_pkg::OP_CLEAR, 17'h1_ffff, 32'hffff_ffff, 32'hffff_ffff,
                 32'hffff_ffff);
    send_command(bcpe_pkg::OP_EVAL, 17'h0_4000, 0, 0, 0);
    for (int i = 0; i < bcpe_pkg::MAX_POINTS; i++) begin
      if (i % 2 == 0) begin
        send_command(bcpe_pkg::OP_APPEND, '0, 32'h7fff_ffff, 32'h8000_0000, rand_coord());
      end else begin
        send_command(bcpe_pkg::OP_APPEND, '0, 32'h8000_0000, 32'h7fff_ffff, rand_coord());
      end
    end
    send_command(bcpe_pkg::OP_APPEND, 17'h0_0000, 32'h1234_5678, 32'h1234_5678,
                 32'h1234_5678);
    send_command(bcpe_pkg::OP_EVAL, 17'd21845, 0, 0, 0);

    src_idle_pct = 0;  sink_stall_pct = 0;  run_random(RANDOM_ITEMS / 4);
    src_idle_pct = 66; sink_stall_pct = 0;  run_random(RANDOM_ITEMS / 4);
    src_idle_pct = 0;  sink_stall_pct = 66; run_random(RANDOM_ITEMS / 4);
    src_idle_pct = 8;  sink_stall_pct = 8;  run_random(RANDOM_ITEMS / 4);
    in_tvalid <= 1'b0;

    while (point_board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (point_board.errors == 0 && point_board.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
